FILE: hdl/huffman_tree_bit_decoder_macros.svh
// Assertion macros for the Huffman tree bit decoder.
// Expects signals named clk and rst_n in the including module.
`ifndef HUFFMAN_TREE_BIT_DECODER_MACROS_SVH
`define HUFFMAN_TREE_BIT_DECODER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define HTBD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define HTBD_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: hdl/htbd_pkg.sv
// Shared types and constants of the Huffman tree bit decoder.
// No dependencies; used by the channel interfaces, the decoder and its testbench.
package htbd_pkg;

    // Width of one decoded symbol.
    localparam int SYM_W = 8;

    // Request type codes.
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_DECODE = 1'b1;

    // Code bit values.
    localparam logic BIT_LEFT  = 1'b0;
    localparam logic BIT_RIGHT = 1'b1;

    // Root record fetch sequencer states.
    typedef enum logic [1:0] {
        FETCH_IDLE,
        FETCH_READ,
        FETCH_LATCH
    } fetch_state_t;

endpackage

FILE: hdl/htbd_if.sv
// Valid/ready channel interfaces of the Huffman tree bit decoder.
// Depends on htbd_pkg for the symbol width.
interface htbd_req_if #(
    parameter int NODE_W = 9
);
    import htbd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [NODE_W-1:0]        node_index;
    logic signed [NODE_W:0]   left_child;
    logic signed [NODE_W:0]   right_child;
    logic [SYM_W-1:0]         node_symbol;
    logic                     code_bit;

    modport source (
        output valid, req_type, node_index, left_child, right_child, node_symbol, code_bit,
        input  ready
    );

    modport sink (
        input  valid, req_type, node_index, left_child, right_child, node_symbol, code_bit,
        output ready
    );
endinterface

interface htbd_sym_if;
    import htbd_pkg::*;

    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] decoded_symbol;

    modport source (
        output valid, decoded_symbol,
        input  ready
    );

    modport sink (
        input  valid, decoded_symbol,
        output ready
    );
endinterface

FILE: hdl/htbd_node_ram.sv
// Node table of the Huffman tree bit decoder: one write port, one read port.
// Read data is registered, so it appears in the cycle after the read request.
module htbd_node_ram #(
    parameter int DEPTH  = 511,
    parameter int ADDR_W = 9,
    parameter int DATA_W = 28
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; data holds while no read is requested.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

FILE: hdl/huffman_tree_bit_decoder.sv
// Huffman tree bit decoder: walks a loaded node table, one code bit per request.
// Throughput: one request per cycle, loads and bits alike; a leaf symbol that waits on a
// full output register stalls requests, as does the root fetch of a symbol_count write.
// Path: a leaf symbol passes the node RAM read register, then, unless stalled, the output
// register; the child RAM read overlaps the child selection for the next bit.
// Reset: walk at root node 2, output empty; the node table is not cleared.
`include "huffman_tree_bit_decoder_macros.svh"

module huffman_tree_bit_decoder #(
    parameter int MAX_SYMBOLS = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    htbd_req_if.sink                           req,
    htbd_sym_if.source                         sym,
    input  logic                               cfg_wr_en,
    input  logic [$clog2(MAX_SYMBOLS+1)-1:0]   cfg_wr_data
);
    import htbd_pkg::*;

    localparam int TABLE_DEPTH = 2 * MAX_SYMBOLS - 1;
    localparam int NODE_W      = $clog2(TABLE_DEPTH);
    localparam int CH_W        = NODE_W + 1;
    localparam int CNT_W       = $clog2(MAX_SYMBOLS + 1);
    localparam int REC_W       = 2 * CH_W + SYM_W;

    localparam logic [NODE_W-1:0] RESET_ROOT  = NODE_W'(2);
    localparam logic [NODE_W-1:0] DEPTH_LIMIT = NODE_W'(TABLE_DEPTH);

    // Registers.
    fetch_state_t       fetch_state_reg, fetch_state_next;
    logic [NODE_W-1:0]  root_reg, root_next;
    logic               at_root_reg, at_root_next;
    logic               pend_reg, pend_next;
    logic [NODE_W-1:0]  node_reg, node_next;
    logic [CH_W-1:0]    cur_left_reg, cur_left_next;
    logic [CH_W-1:0]    cur_right_reg, cur_right_next;
    logic [CH_W-1:0]    root_left_reg, root_left_next;
    logic [CH_W-1:0]    root_right_reg, root_right_next;
    logic               out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]   out_sym_reg, out_sym_next;

    // Combinational signals.
    logic               fetch_rd;
    logic               fetch_latch;
    logic               fetch_busy;
    logic [CNT_W-1:0]   cnt_clamped;
    logic [NODE_W:0]    cnt_double;
    logic [NODE_W-1:0]  root_cfg;
    logic [REC_W-1:0]   rd_data;
    logic [CH_W-1:0]    md_left;
    logic [CH_W-1:0]    md_right;
    logic [SYM_W-1:0]   md_sym;
    logic               md_leaf;
    logic               out_free;
    logic               stall;
    logic               req_accept;
    logic               acc_load;
    logic               acc_dec;
    logic               eff_root;
    logic [CH_W-1:0]    eff_left;
    logic [CH_W-1:0]    eff_right;
    logic [CH_W-1:0]    child;
    logic               child_ok;
    logic               dec_rd;
    logic               wr_en;
    logic               rd_en;
    logic [NODE_W-1:0]  rd_addr;
    logic [REC_W-1:0]   wr_data;

    // Root index from a written symbol count, clamped to the legal range.
    always_comb
    begin
        cnt_clamped = cfg_wr_data;
        priority if (cfg_wr_data < CNT_W'(2))
        begin
            cnt_clamped = CNT_W'(2);
        end
        else if (cfg_wr_data > CNT_W'(MAX_SYMBOLS))
        begin
            cnt_clamped = CNT_W'(MAX_SYMBOLS);
        end
        else
        begin
            cnt_clamped = cfg_wr_data;
        end
        cnt_double = (NODE_W + 1)'(cnt_clamped) << 1;
        root_cfg   = NODE_W'(cnt_double - (NODE_W + 1)'(2));
    end

    // Root fetch sequencer: next state.
    always_comb
    begin
        fetch_state_next = fetch_state_reg;
        unique case (fetch_state_reg)
            FETCH_IDLE:  fetch_state_next = FETCH_IDLE;
            FETCH_READ:  fetch_state_next = FETCH_LATCH;
            FETCH_LATCH: fetch_state_next = FETCH_IDLE;
            default:     fetch_state_next = FETCH_IDLE;
        endcase
        if (cfg_wr_en)
        begin
            fetch_state_next = FETCH_READ;
        end
    end

    // Root fetch sequencer: outputs.
    always_comb
    begin
        fetch_rd    = 1'b0;
        fetch_latch = 1'b0;
        fetch_busy  = 1'b0;
        unique case (fetch_state_reg)
            FETCH_IDLE:
            begin
                fetch_busy = 1'b0;
            end
            FETCH_READ:
            begin
                fetch_rd   = 1'b1;
                fetch_busy = 1'b1;
            end
            FETCH_LATCH:
            begin
                fetch_latch = 1'b1;
                fetch_busy  = 1'b1;
            end
            default:
            begin
                fetch_busy = 1'b1;
            end
        endcase
    end

    // Node record read back from the RAM.
    assign md_left  = rd_data[REC_W-1 -: CH_W];
    assign md_right = rd_data[SYM_W +: CH_W];
    assign md_sym   = rd_data[SYM_W-1:0];
    assign md_leaf  = pend_reg && (md_left == '1) && (md_right == '1);

    // Handshake: a leaf result waiting for a full output register holds the walk.
    assign out_free   = !out_valid_reg || sym.ready;
    assign stall      = md_leaf && !out_free;
    assign req.ready  = !fetch_busy && !stall;
    assign req_accept = req.valid && req.ready;
    assign acc_load   = req_accept && (req.req_type == REQ_LOAD);
    assign acc_dec    = req_accept && (req.req_type == REQ_DECODE);

    // Current node after resolving the pending read.
    always_comb
    begin
        eff_root = pend_reg ? md_leaf : at_root_reg;
        if (eff_root)
        begin
            eff_left  = root_left_reg;
            eff_right = root_right_reg;
        end
        else if (pend_reg)
        begin
            eff_left  = md_left;
            eff_right = md_right;
        end
        else
        begin
            eff_left  = cur_left_reg;
            eff_right = cur_right_reg;
        end
    end

    // Child selection and range check.
    assign child    = (req.code_bit == BIT_RIGHT) ? eff_right : eff_left;
    assign child_ok = !child[CH_W-1] && (child[NODE_W-1:0] < DEPTH_LIMIT);
    assign dec_rd   = acc_dec && child_ok;

    // RAM ports.
    assign wr_en   = acc_load && (req.node_index < DEPTH_LIMIT);
    assign wr_data = {req.left_child, req.right_child, req.node_symbol};
    assign rd_en   = fetch_rd || dec_rd;
    assign rd_addr = fetch_rd ? root_reg : child[NODE_W-1:0];

    htbd_node_ram #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (NODE_W),
        .DATA_W (REC_W)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (req.node_index),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Walk state, node copies and output register: next values.
    always_comb
    begin
        root_next       = root_reg;
        at_root_next    = at_root_reg;
        pend_next       = pend_reg;
        node_next       = node_reg;
        cur_left_next   = cur_left_reg;
        cur_right_next  = cur_right_reg;
        root_left_next  = root_left_reg;
        root_right_next = root_right_reg;
        out_valid_next  = out_valid_reg && !sym.ready;
        out_sym_next    = out_sym_reg;

        if (!stall)
        begin
            if (acc_dec)
            begin
                // A valid child starts a read; a bad one sends the walk home.
                pend_next    = child_ok;
                at_root_next = !child_ok;
                if (child_ok)
                begin
                    node_next = child[NODE_W-1:0];
                end
            end
            else
            begin
                pend_next      = 1'b0;
                at_root_next   = eff_root;
                cur_left_next  = eff_left;
                cur_right_next = eff_right;
                // A load that rewrites the current node updates its copy.
                if (wr_en && (req.node_index == node_reg) && !eff_root)
                begin
                    cur_left_next  = req.left_child;
                    cur_right_next = req.right_child;
                end
            end

            // A load that rewrites the root updates the root copy.
            if (wr_en && (req.node_index == root_reg))
            begin
                root_left_next  = req.left_child;
                root_right_next = req.right_child;
            end

            // A leaf reached by the previous bit goes to the output register.
            if (md_leaf)
            begin
                out_valid_next = 1'b1;
                out_sym_next   = md_sym;
            end
        end

        // The root record arrives from the fetch read.
        if (fetch_latch)
        begin
            root_left_next  = md_left;
            root_right_next = md_right;
        end

        // A new symbol count moves the walk to the new root.
        if (cfg_wr_en)
        begin
            root_next    = root_cfg;
            at_root_next = 1'b1;
            pend_next    = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fetch_state_reg <= FETCH_IDLE;
            root_reg        <= RESET_ROOT;
            at_root_reg     <= 1'b1;
            pend_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            fetch_state_reg <= fetch_state_next;
            root_reg        <= root_next;
            at_root_reg     <= at_root_next;
            pend_reg        <= pend_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        node_reg       <= node_next;
        cur_left_reg   <= cur_left_next;
        cur_right_reg  <= cur_right_next;
        root_left_reg  <= root_left_next;
        root_right_reg <= root_right_next;
        out_sym_reg    <= out_sym_next;
    end

    assign sym.valid          = out_valid_reg;
    assign sym.decoded_symbol = out_sym_reg;

    // Checks on the walk and fetch logic.
    `HTBD_ASSERT(a_cfg_blocks_requests, cfg_wr_en |=> !req_accept ##1 !req_accept,
        "request taken during root fetch")
    `HTBD_ASSERT(a_pend_from_read, $rose(pend_reg) |-> $past(rd_en),
        "pending node without a RAM read")
    `HTBD_ASSERT(a_result_from_leaf, $rose(out_valid_reg) |-> $past(pend_reg),
        "result without a node read")
    `HTBD_ASSERT_NEVER(a_pend_at_root, pend_reg && at_root_reg, "walk both pending and at root")
endmodule

FILE: tb/sv/tb_huffman_tree_bit_decoder.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Huffman tree bit decoder: node loads, code bits and
// symbol_count writes, checked against a tree-walk predictor. Needs htbd_pkg,
// the channel interfaces of htbd_if.sv and the decoder RTL.
module tb_huffman_tree_bit_decoder;
    import htbd_pkg::*;

    localparam int MAX_SYMBOLS  = 256;
    localparam int TABLE_DEPTH  = 2 * MAX_SYMBOLS - 1;
    localparam int CNT_W        = $clog2(MAX_SYMBOLS + 1);
    localparam int ITEM_TARGET  = 700;
    localparam int CALM_TAIL    = 100;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;

    // Two copies of the walk: one advanced while requests are generated, one on acceptance.
    localparam int PLAN  = 0;
    localparam int CHECK = 1;

    localparam logic signed [9:0] NO_CHILD = -10'sd1;

    typedef struct packed {
        logic       req_type;
        logic [8:0] node_index;
        logic [9:0] left_child;
        logic [9:0] right_child;
        logic [7:0] node_symbol;
        logic       code_bit;
    } tree_op_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CNT_W-1:0] cfg_wr_data;

    htbd_req_if #(.NODE_W(9)) req_ch ();
    htbd_sym_if               sym_ch ();

    huffman_tree_bit_decoder #(
        .MAX_SYMBOLS(MAX_SYMBOLS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .sym         (sym_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Predicted node table and walk position, one copy per index.
    logic signed [9:0] left_of   [2][TABLE_DEPTH];
    logic signed [9:0] right_of  [2][TABLE_DEPTH];
    logic [7:0]        symbol_of [2][TABLE_DEPTH];
    bit                loaded    [2][TABLE_DEPTH];
    int                walk_pos  [2];
    int                leaf_count[2];

    tree_op_t   pending_ops[$];
    logic [7:0] expected_symbols[$];

    int n_queued;
    int n_accepted;
    int n_loads;
    int n_bits;
    int n_symbols;
    int n_cfg_writes;
    int n_errors;
    int n_cycles;
    int req_idle_pct = 15;
    int sym_idle_pct = 15;
    int req_gap;
    int sym_gap;
    bit req_fired;

    function automatic int root_of(int count);
        int c;
        c = count;
        if (c < 2)
            c = 2;
        if (c > MAX_SYMBOLS)
            c = MAX_SYMBOLS;
        return 2 * c - 2;
    endfunction

    function automatic void set_leaf_count(int k, int value);
        leaf_count[k] = value;
        walk_pos[k]   = root_of(value);
    endfunction

    // Applies one request to walk copy k; returns 1 when a leaf symbol is produced.
    function automatic bit walk_tree(int k, tree_op_t op, output logic [7:0] symbol);
        int slot;
        int nxt;
        symbol = '0;
        if (op.req_type == REQ_LOAD)
        begin
            slot = op.node_index;
            if (slot < TABLE_DEPTH)
            begin
                left_of[k][slot]   = op.left_child;
                right_of[k][slot]  = op.right_child;
                symbol_of[k][slot] = op.node_symbol;
                loaded[k][slot]    = 1'b1;
            end
            return 1'b0;
        end
        if (walk_pos[k] >= TABLE_DEPTH)
        begin
            walk_pos[k] = root_of(leaf_count[k]);
            return 1'b0;
        end
        nxt = (op.code_bit == BIT_RIGHT) ? int'(right_of[k][walk_pos[k]])
                                         : int'(left_of[k][walk_pos[k]]);
        // A missing or out-of-table child sends the walk back to the root silently.
        if (nxt < 0 || nxt >= TABLE_DEPTH)
        begin
            walk_pos[k] = root_of(leaf_count[k]);
            return 1'b0;
        end
        if (left_of[k][nxt] == NO_CHILD && right_of[k][nxt] == NO_CHILD)
        begin
            symbol      = symbol_of[k][nxt];
            walk_pos[k] = root_of(leaf_count[k]);
            return 1'b1;
        end
        walk_pos[k] = nxt;
        return 1'b0;
    endfunction

    // True when following this bit reads only table entries that were loaded.
    function automatic bit bit_is_safe(logic code_bit);
        int nxt;
        if (!loaded[PLAN][walk_pos[PLAN]])
            return 1'b0;
        nxt = (code_bit == BIT_RIGHT) ? int'(right_of[PLAN][walk_pos[PLAN]])
                                      : int'(left_of[PLAN][walk_pos[PLAN]]);
        if (nxt < 0 || nxt >= TABLE_DEPTH)
            return 1'b1;
        return loaded[PLAN][nxt];
    endfunction

    function automatic tree_op_t load_op(int idx, int lc, int rc, int symbol);
        tree_op_t op;
        op.req_type    = REQ_LOAD;
        op.node_index  = 9'(idx);
        op.left_child  = 10'(lc);
        op.right_child = 10'(rc);
        op.node_symbol = 8'(symbol);
        op.code_bit    = 1'($urandom_range(0, 1));
        return op;
    endfunction

    // Decode request; the load fields carry noise that the block must ignore.
    function automatic tree_op_t bit_op(logic b);
        tree_op_t op;
        op.req_type    = REQ_DECODE;
        op.node_index  = 9'($urandom_range(0, 511));
        op.left_child  = 10'($urandom_range(0, 1023));
        op.right_child = 10'($urandom_range(0, 1023));
        op.node_symbol = 8'($urandom_range(0, 255));
        op.code_bit    = b;
        return op;
    endfunction

    function automatic int random_child();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return -1;
        if (r < 8)
            return $urandom_range(0, TABLE_DEPTH - 1);
        return int'($urandom_range(0, 1023)) - 512;
    endfunction

    function automatic void queue_op(tree_op_t op);
        logic [7:0] ignored;
        pending_ops.push_back(op);
        void'(walk_tree(PLAN, op, ignored));
        n_queued++;
    endfunction

    // Queues a code bit, flipping it or filling a missing node so no unloaded entry is read.
    function automatic void queue_bit(logic b);
        int slot;
        if (!bit_is_safe(b))
            b = ~b;
        if (bit_is_safe(b))
        begin
            queue_op(bit_op(b));
            return;
        end
        if (!loaded[PLAN][walk_pos[PLAN]])
            slot = walk_pos[PLAN];
        else
            slot = (b == BIT_RIGHT) ? int'(right_of[PLAN][walk_pos[PLAN]])
                                    : int'(left_of[PLAN][walk_pos[PLAN]]);
        queue_op(load_op(slot, -1, -1, $urandom_range(0, 255)));
    endfunction

    function automatic bit calm_tail();
        return n_accepted >= ITEM_TARGET - CALM_TAIL;
    endfunction

    // Builds a random tree on scattered slots with the given root and queues its loads.
    task automatic load_random_tree(int root, int leaves);
        int       slots[$];
        int       pool[$];
        tree_op_t loads[$];
        tree_op_t tmp;
        bit       taken[TABLE_DEPTH];
        int       cand;
        int       pick;
        int       kid0;
        int       kid1;
        int       j;
        taken[root] = 1'b1;
        while (slots.size() < 2 * leaves - 2)
        begin
            cand = $urandom_range(0, TABLE_DEPTH - 1);
            if (!taken[cand])
            begin
                taken[cand] = 1'b1;
                slots.push_back(cand);
            end
        end
        slots.push_back(root);
        for (int i = 0; i < leaves; i++)
        begin
            loads.push_back(load_op(slots[i], -1, -1, $urandom_range(0, 255)));
            pool.push_back(slots[i]);
        end
        // Merge two subtrees per internal node; the last node made is the root.
        for (int i = leaves; i < 2 * leaves - 1; i++)
        begin
            pick = $urandom_range(0, pool.size() - 1);
            kid0 = pool[pick];
            pool.delete(pick);
            pick = $urandom_range(0, pool.size() - 1);
            kid1 = pool[pick];
            pool.delete(pick);
            loads.push_back(load_op(slots[i], kid0, kid1, $urandom_range(0, 255)));
            pool.push_back(slots[i]);
        end
        for (int i = loads.size() - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = loads[i];
            loads[i] = loads[j];
            loads[j] = tmp;
        end
        foreach (loads[i])
            queue_op(loads[i]);
    endtask

    // Waits until every request is taken and every symbol has come out, plus a margin.
    task automatic wait_for_idle();
        do
        begin
            while (pending_ops.size() != 0 || expected_symbols.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
        while (pending_ops.size() != 0 || expected_symbols.size() != 0);
    endtask

    task automatic write_leaf_count(int value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CNT_W'(value);
        set_leaf_count(PLAN, value);
        set_leaf_count(CHECK, value);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        n_cfg_writes++;
    endtask

    // One phase: load a tree under the new root, write symbol_count, then walk it amid random loads.
    task automatic run_phase(int count_value, int leaves, int n_ops);
        int r;
        int pos;
        int pcts[3];
        pcts = '{0, 15, 40};
        load_random_tree(root_of(count_value), leaves);
        wait_for_idle();
        write_leaf_count(count_value);
        req_idle_pct = pcts[$urandom_range(0, 2)];
        sym_idle_pct = pcts[$urandom_range(0, 2)];
        for (int i = 0; i < n_ops; i++)
        begin
            r   = $urandom_range(0, 99);
            pos = walk_pos[PLAN];
            if (r < 82)
                queue_bit(1'($urandom_range(0, 1)));
            else if (r < 94 || !loaded[PLAN][pos])
                queue_op(load_op($urandom_range(0, 511), random_child(), random_child(),
                                 $urandom_range(0, 255)));
            else
                // Rewrite the node the walk stands on, children swapped.
                queue_op(load_op(pos, right_of[PLAN][pos], left_of[PLAN][pos],
                                 $urandom_range(0, 255)));
        end
    endtask

    // Clock generator.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle counter that ends a hung run.
    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d requests and %0d symbols outstanding.",
                     n_cycles, pending_ops.size(), expected_symbols.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Accepted requests advance the checking copy of the walk.
    always @(posedge clk)
    begin : take_request
        tree_op_t   op;
        logic [7:0] symbol;
        req_fired = rst_n && req_ch.valid && req_ch.ready;
        if (req_fired)
        begin
            op = pending_ops.pop_front();
            if (walk_tree(CHECK, op, symbol))
                expected_symbols.push_back(symbol);
            if (op.req_type == REQ_LOAD)
                n_loads++;
            else
                n_bits++;
            n_accepted++;
        end
    end

    // Request driver: holds a shown request until it is taken, idles in bursts.
    always @(negedge clk)
    begin : drive_request
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_ch.valid || req_fired)
        begin
            if (req_gap > 0)
            begin
                req_gap--;
                req_ch.valid <= 1'b0;
            end
            else if (!calm_tail() && $urandom_range(0, 99) < req_idle_pct)
            begin
                req_gap = $urandom_range(0, 9);
                req_ch.valid <= 1'b0;
            end
            else if (pending_ops.size() > 0)
            begin
                req_ch.valid       <= 1'b1;
                req_ch.req_type    <= pending_ops[0].req_type;
                req_ch.node_index  <= pending_ops[0].node_index;
                req_ch.left_child  <= pending_ops[0].left_child;
                req_ch.right_child <= pending_ops[0].right_child;
                req_ch.node_symbol <= pending_ops[0].node_symbol;
                req_ch.code_bit    <= pending_ops[0].code_bit;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Symbol ready with random stall bursts.
    always @(negedge clk)
    begin : drive_ready
        if (!rst_n)
            sym_ch.ready <= 1'b0;
        else if (sym_gap > 0)
        begin
            sym_gap--;
            sym_ch.ready <= 1'b0;
        end
        else if (!calm_tail() && $urandom_range(0, 99) < sym_idle_pct)
        begin
            sym_gap = $urandom_range(0, 9);
            sym_ch.ready <= 1'b0;
        end
        else
            sym_ch.ready <= 1'b1;
    end

    // Symbol monitor: each symbol taken is checked against the oldest prediction.
    always @(posedge clk)
    begin : check_symbol
        logic [7:0] want;
        if (rst_n && sym_ch.valid && sym_ch.ready)
        begin
            if (expected_symbols.size() == 0)
            begin
                $error("decoded_symbol: expected none, actual 0x%02h", sym_ch.decoded_symbol);
                n_errors++;
            end
            else
            begin
                want = expected_symbols.pop_front();
                if (sym_ch.decoded_symbol !== want)
                begin
                    $error("decoded_symbol: expected 0x%02h, actual 0x%02h",
                           want, sym_ch.decoded_symbol);
                    n_errors++;
                end
                n_symbols++;
            end
        end
    end

    // Stimulus: reset, directed cases, then random phases over many symbol counts.
    initial
    begin : stimulus
        int count_values[$];
        int r;
        int count_value;
        int leaves;
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_LOAD;
        req_ch.node_index  = '0;
        req_ch.left_child  = '0;
        req_ch.right_child = '0;
        req_ch.node_symbol = '0;
        req_ch.code_bit    = BIT_LEFT;
        sym_ch.ready       = 1'b0;
        set_leaf_count(PLAN, 2);
        set_leaf_count(CHECK, 2);
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Smallest tree under the reset root: two leaves with the extreme symbols.
        queue_op(load_op(0, -1, -1, 8'h00));
        queue_op(load_op(1, -1, -1, 8'hFF));
        queue_op(load_op(2, 0, 1, 8'h5A));
        queue_op(bit_op(BIT_LEFT));
        queue_op(bit_op(BIT_RIGHT));
        // A slot past the table is ignored.
        queue_op(load_op(511, -512, 511, 8'hA5));
        // Bad children: negative beyond none, and one past the table.
        queue_op(load_op(2, 0, -512, 8'h00));
        queue_op(bit_op(BIT_RIGHT));
        queue_op(bit_op(BIT_LEFT));
        queue_op(load_op(2, 0, 511, 8'h00));
        queue_op(bit_op(BIT_RIGHT));
        // An inner node with only one child; the missing side returns to the root.
        queue_op(load_op(4, -1, 0, 8'h33));
        queue_op(load_op(2, 4, 1, 8'h00));
        queue_op(bit_op(BIT_LEFT));
        queue_op(bit_op(BIT_LEFT));
        queue_op(bit_op(BIT_LEFT));
        queue_op(bit_op(BIT_RIGHT));
        // Reloading the node the walk stands on.
        queue_op(bit_op(BIT_LEFT));
        queue_op(load_op(4, 1, -1, 8'h77));
        queue_op(bit_op(BIT_LEFT));
        // A root that is itself a leaf gives nothing.
        queue_op(load_op(2, -1, -1, 8'h11));
        queue_op(bit_op(BIT_LEFT));

        // Counts below, at and above the legal range, then random ones.
        count_values = '{0, 1, 256, 257, 511, 2, 3};
        foreach (count_values[i])
            run_phase(count_values[i], $urandom_range(2, 6), $urandom_range(20, 40));
        while (n_queued < ITEM_TARGET)
        begin
            r           = $urandom_range(0, 99);
            count_value = (r < 15) ? $urandom_range(0, 511) : $urandom_range(2, 40);
            leaves      = (r % 10 == 0) ? $urandom_range(9, 24) : $urandom_range(2, 8);
            run_phase(count_value, leaves, $urandom_range(30, 60));
        end
        wait_for_idle();

        $display("Run covered %0d node loads, %0d code bits and %0d symbol_count writes.",
                 n_loads, n_bits, n_cfg_writes);
        $display("%0d decoded symbols were compared; %0d mismatches.", n_symbols, n_errors);
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/htbd_pkg.sv
hdl/htbd_if.sv
hdl/htbd_node_ram.sv
hdl/huffman_tree_bit_decoder.sv
tb/sv/tb_huffman_tree_bit_decoder.sv
